[rtl/vnavg_pkg.sv]
// ----------------------------------------------------------------------------
// vnavg_pkg
// Shared sizes and operation codes of the vertex normal averager.
// ----------------------------------------------------------------------------
`default_nettype none

package vnavg_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int SUM_W        = 24;
   localparam int POS_W        = 32;
   localparam int NRM_W        = 16;
   localparam int FUNC_W       = 2;

   localparam logic [FUNC_W-1:0] FUNC_LOAD     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TRIANGLE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd2;

   // unit length in Q2.14
   localparam int NRM_ONE = 16384;

endpackage

`default_nettype wire

[rtl/vertex_normal_averager_top.sv]
// ----------------------------------------------------------------------------
// vertex_normal_averager_top
// Smooth vertex normals: loads positions, accumulates unit face normals of
// triangles into per-vertex saturating sums, reads back normalized sums.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high while
// the item is worked on. A load is done at the accepting edge and never raises
// busy. After the accepting edge busy stays high through the whole work on a
// triangle (it falls early for a zero-area face) and on a read (early when the
// sum is zero): one multiplier does the six cross products and three squares,
// and one 64-bit subtractor does the 32-step square root and the 3 x 16-step
// divides; a shift loop first brings the vector into range. A triangle also
// goes through edge prescale and the read-modify-write of the three sums. A
// read result is shown on the rsp_ ports for one cycle with rsp_valid high, in
// the cycle in which busy falls, and must be taken then: the receiver cannot
// stall. After reset, busy stays high while the sum memory is cleared.
`default_nettype none

module vertex_normal_averager_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [vnavg_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [vnavg_pkg::VTX_W-1:0]       req_index_a,
   input  wire logic [vnavg_pkg::VTX_W-1:0]       req_index_b,
   input  wire logic [vnavg_pkg::VTX_W-1:0]       req_index_c,
   input  wire logic signed [vnavg_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [vnavg_pkg::POS_W-1:0] req_pos_y,
   input  wire logic signed [vnavg_pkg::POS_W-1:0] req_pos_z,
   output logic                                   rsp_valid,
   output logic [vnavg_pkg::VTX_W-1:0]            rsp_vertex_index,
   output logic signed [vnavg_pkg::NRM_W-1:0]     rsp_normal_x,
   output logic signed [vnavg_pkg::NRM_W-1:0]     rsp_normal_y,
   output logic signed [vnavg_pkg::NRM_W-1:0]     rsp_normal_z,
   output logic                                   rsp_zero_normal
);

   localparam int VTX_W = vnavg_pkg::VTX_W;
   localparam int SUM_W = vnavg_pkg::SUM_W;
   localparam int POS_W = vnavg_pkg::POS_W;
   localparam int NRM_W = vnavg_pkg::NRM_W;
   localparam int DEPTH = vnavg_pkg::MAX_VERTICES;
   localparam logic [VTX_W:0] VTX_LIMIT = (VTX_W+1)'(vnavg_pkg::MAX_VERTICES);
   localparam logic [VTX_W-1:0] CLR_LAST = VTX_W'(vnavg_pkg::MAX_VERTICES - 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RDPOS    = 4'd2;
   localparam logic [3:0] S_PRESCALE = 4'd3;
   localparam logic [3:0] S_CROSS    = 4'd4;
   localparam logic [3:0] S_RDSUM    = 4'd5;
   localparam logic [3:0] S_NORM     = 4'd6;
   localparam logic [3:0] S_SQ       = 4'd7;
   localparam logic [3:0] S_SQRT     = 4'd8;
   localparam logic [3:0] S_DIV      = 4'd9;
   localparam logic [3:0] S_FIN      = 4'd10;
   localparam logic [3:0] S_ACC      = 4'd11;

   // memories
   logic [3*POS_W-1:0] pos_mem [DEPTH];
   logic [3*SUM_W-1:0] sum_mem [DEPTH];
   logic [3*POS_W-1:0] pos_rd_ff;
   logic [3*SUM_W-1:0] sum_rd_ff;
   logic               pos_we, sum_we;
   logic [VTX_W-1:0]   pos_waddr, pos_raddr, sum_waddr, sum_raddr;
   logic [3*POS_W-1:0] pos_wdata;
   logic [3*SUM_W-1:0] sum_wdata;

   // sequencer state
   logic [3:0]        state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [1:0]        comp_ff, comp_in;
   logic [VTX_W-1:0]  clr_ff, clr_in;
   logic              mode_read_ff, mode_read_in;
   logic [VTX_W-1:0]  idx_a_ff, idx_a_in, idx_b_ff, idx_b_in, idx_c_ff, idx_c_in;

   // datapath
   logic [POS_W-1:0]  pa_ff [3];
   logic [POS_W-1:0]  pa_in [3];
   logic [POS_W:0]    e_mag_ff [6];
   logic [POS_W:0]    e_mag_in [6];
   logic [5:0]        e_neg_ff, e_neg_in;
   logic [63:0]       mult_ff, mult_in;
   logic              mneg_ff, mneg_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0]       v_mag_ff [3];
   logic [63:0]       v_mag_in [3];
   logic [2:0]        v_neg_ff, v_neg_in;
   logic [63:0]       s_ff, s_in, rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [14:0]       q_ff, q_in;
   logic [NRM_W-1:0]  n_ff [3];
   logic [NRM_W-1:0]  n_in [3];

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [NRM_W-1:0]  rsp_n_ff [3];
   logic [NRM_W-1:0]  rsp_n_in [3];
   logic              rsp_zero_ff, rsp_zero_in;

   // shared units
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic [63:0]       sub_a, sub_b;
   logic [64:0]       sub_diff;
   logic              sub_ge;

   assign mul_p    = mul_a * mul_b;
   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[64];

   function automatic logic [POS_W+1:0] diff_mag(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] q);
      logic signed [POS_W:0] d;
      logic [POS_W:0]        m;
      d = $signed({p[POS_W-1], p}) - $signed({q[POS_W-1], q});
      m = d[POS_W] ? (POS_W+1)'(-d) : d;
      return {d[POS_W], m};
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [NRM_W-1:0] b);
      logic signed [SUM_W:0] s;
      logic signed [SUM_W:0] hi;
      logic signed [SUM_W:0] lo;
      hi = {2'b00, {(SUM_W-1){1'b1}}};
      lo = {2'b11, {(SUM_W-1){1'b0}}};
      s  = $signed({a[SUM_W-1], a}) + (SUM_W+1)'($signed(b));
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return s[SUM_W-1:0];
   endfunction

   logic              accept, in_a, in_b, in_c;
   logic [63:0]       v_all;
   logic [POS_W:0]    e_all;
   logic [POS_W+1:0]  dm [3];
   logic signed [63:0] prod_s, cr_sum;
   logic [14:0]       q_fin;
   logic [NRM_W-1:0]  n_new;
   logic [VTX_W-1:0]  acc_idx;
   logic signed [63:0] sx [3];

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && (state_ff == S_IDLE);
   assign in_a   = {1'b0, req_index_a} < VTX_LIMIT;
   assign in_b   = {1'b0, req_index_b} < VTX_LIMIT;
   assign in_c   = {1'b0, req_index_c} < VTX_LIMIT;
   assign v_all  = v_mag_ff[0] | v_mag_ff[1] | v_mag_ff[2];
   assign e_all  = e_mag_ff[0] | e_mag_ff[1] | e_mag_ff[2] |
                   e_mag_ff[3] | e_mag_ff[4] | e_mag_ff[5];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      clr_in       = clr_ff;
      mode_read_in = mode_read_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      idx_c_in     = idx_c_ff;
      pa_in        = pa_ff;
      e_mag_in     = e_mag_ff;
      e_neg_in     = e_neg_ff;
      mult_in      = mult_ff;
      mneg_in      = mneg_ff;
      acc_in       = acc_ff;
      v_mag_in     = v_mag_ff;
      v_neg_in     = v_neg_ff;
      s_in         = s_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_zero_in  = rsp_zero_ff;
      pos_we       = 1'b0;
      pos_waddr    = req_index_a;
      pos_wdata    = {req_pos_x, req_pos_y, req_pos_z};
      pos_raddr    = idx_a_ff;
      sum_we       = 1'b0;
      sum_waddr    = req_index_a;
      sum_wdata    = '0;
      sum_raddr    = idx_a_ff;
      mul_a        = v_mag_ff[0][31:0];
      mul_b        = v_mag_ff[0][31:0];
      sub_a        = rem_ff;
      sub_b        = res_ff | bit_ff;
      dm[0]        = diff_mag(pos_rd_ff[3*POS_W-1:2*POS_W], pa_ff[0]);
      dm[1]        = diff_mag(pos_rd_ff[2*POS_W-1:POS_W], pa_ff[1]);
      dm[2]        = diff_mag(pos_rd_ff[POS_W-1:0], pa_ff[2]);
      prod_s       = mneg_ff ? -$signed(mult_ff) : $signed(mult_ff);
      cr_sum       = acc_ff + prod_s;
      q_fin        = {q_ff[13:0], sub_ge};
      n_new        = v_neg_ff[0] ? NRM_W'(-$signed({1'b0, q_fin}))
                                 : NRM_W'({1'b0, q_fin});
      sx[0]        = 64'($signed(sum_rd_ff[3*SUM_W-1:2*SUM_W]));
      sx[1]        = 64'($signed(sum_rd_ff[2*SUM_W-1:SUM_W]));
      sx[2]        = 64'($signed(sum_rd_ff[SUM_W-1:0]));
      case (comp_ff)
         2'd0:    acc_idx = idx_a_ff;
         2'd1:    acc_idx = idx_b_ff;
         default: acc_idx = idx_c_ff;
      endcase

      case (state_ff)
         S_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               idx_a_in = req_index_a;
               idx_b_in = req_index_b;
               idx_c_in = req_index_c;
               cnt_in   = '0;
               case (req_func)
                  vnavg_pkg::FUNC_LOAD: begin
                     pos_we = in_a;
                     sum_we = in_a;
                  end
                  vnavg_pkg::FUNC_TRIANGLE: begin
                     mode_read_in = 1'b0;
                     if (in_a && in_b && in_c) state_in = S_RDPOS;
                  end
                  vnavg_pkg::FUNC_READ: begin
                     mode_read_in = 1'b1;
                     if (in_a) begin
                        state_in = S_RDSUM;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_idx_in   = req_index_a;
                        rsp_n_in     = '{'0, '0, '0};
                        rsp_zero_in  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RDPOS: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               5'd0: pos_raddr = idx_a_ff;
               5'd1: begin
                  pos_raddr = idx_b_ff;
                  pa_in[0]  = pos_rd_ff[3*POS_W-1:2*POS_W];
                  pa_in[1]  = pos_rd_ff[2*POS_W-1:POS_W];
                  pa_in[2]  = pos_rd_ff[POS_W-1:0];
               end
               5'd2: begin
                  pos_raddr = idx_c_ff;
                  for (int i = 0; i < 3; i++) begin
                     e_mag_in[i] = dm[i][POS_W:0];
                     e_neg_in[i] = dm[i][POS_W+1];
                  end
               end
               default: begin
                  for (int i = 0; i < 3; i++) begin
                     e_mag_in[i+3] = dm[i][POS_W:0];
                     e_neg_in[i+3] = dm[i][POS_W+1];
                  end
                  state_in = S_PRESCALE;
               end
            endcase
         end
         S_PRESCALE: begin
            // truncate all edges together until the largest is below 2^30
            if (|e_all[POS_W:30]) begin
               for (int i = 0; i < 6; i++) e_mag_in[i] = e_mag_ff[i] >> 1;
            end else begin
               cnt_in   = '0;
               state_in = S_CROSS;
            end
         end
         S_CROSS: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               5'd0: begin mul_a = e_mag_ff[1][31:0]; mul_b = e_mag_ff[5][31:0];
                  mneg_in = e_neg_ff[1] ^ e_neg_ff[5]; end
               5'd1: begin mul_a = e_mag_ff[2][31:0]; mul_b = e_mag_ff[4][31:0];
                  mneg_in = !(e_neg_ff[2] ^ e_neg_ff[4]); end
               5'd2: begin mul_a = e_mag_ff[2][31:0]; mul_b = e_mag_ff[3][31:0];
                  mneg_in = e_neg_ff[2] ^ e_neg_ff[3]; end
               5'd3: begin mul_a = e_mag_ff[0][31:0]; mul_b = e_mag_ff[5][31:0];
                  mneg_in = !(e_neg_ff[0] ^ e_neg_ff[5]); end
               5'd4: begin mul_a = e_mag_ff[0][31:0]; mul_b = e_mag_ff[4][31:0];
                  mneg_in = e_neg_ff[0] ^ e_neg_ff[4]; end
               5'd5: begin mul_a = e_mag_ff[1][31:0]; mul_b = e_mag_ff[3][31:0];
                  mneg_in = !(e_neg_ff[1] ^ e_neg_ff[3]); end
               default: state_in = S_NORM;
            endcase
            mult_in = mul_p;
            if (cnt_ff != 5'd0) begin
               if (cnt_ff[0]) begin
                  acc_in = prod_s;
               end else begin
                  // shift finished component in from the top
                  v_mag_in[0] = v_mag_ff[1];
                  v_mag_in[1] = v_mag_ff[2];
                  v_mag_in[2] = cr_sum[63] ? 64'(-cr_sum) : 64'(cr_sum);
                  v_neg_in    = {cr_sum[63], v_neg_ff[2:1]};
               end
            end
         end
         S_RDSUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != 5'd0) begin
               for (int i = 0; i < 3; i++) begin
                  v_mag_in[i] = sx[i][63] ? 64'(-sx[i]) : 64'(sx[i]);
                  v_neg_in[i] = sx[i][63];
               end
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (v_all == 64'd0) begin
               state_in = S_IDLE;
               if (mode_read_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = idx_a_ff;
                  rsp_n_in     = '{'0, '0, '0};
                  rsp_zero_in  = 1'b1;
               end
            end else if (|v_all[63:38]) begin
               for (int i = 0; i < 3; i++) v_mag_in[i] = v_mag_ff[i] >> 8;
            end else if (|v_all[63:30]) begin
               for (int i = 0; i < 3; i++) v_mag_in[i] = v_mag_ff[i] >> 1;
            end else if (v_all[63:21] == '0) begin
               for (int i = 0; i < 3; i++) v_mag_in[i] = v_mag_ff[i] << 8;
            end else if (!v_all[29]) begin
               for (int i = 0; i < 3; i++) v_mag_in[i] = v_mag_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd3) begin
               rem_in   = s_ff + mult_ff;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = S_SQRT;
            end else begin
               mult_in     = mul_p;
               s_in        = (cnt_ff == 5'd0) ? 64'd0 : s_ff + mult_ff;
               v_mag_in[0] = v_mag_ff[1];
               v_mag_in[1] = v_mag_ff[2];
               v_mag_in[2] = v_mag_ff[0];
               v_neg_in    = {v_neg_ff[0], v_neg_ff[2:1]};
            end
         end
         S_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            if (sub_ge) begin
               rem_in = sub_diff[63:0];
               res_in = (res_ff >> 1) | bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == 5'd31) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            sub_b  = res_ff << (4'd15 - cnt_ff[3:0]);
            if (cnt_ff == 5'd0) begin
               rem_in = {20'd0, v_mag_ff[0][29:0], 14'd0} + (res_ff >> 1);
               q_in   = '0;
            end else begin
               q_in = q_fin;
               if (sub_ge) rem_in = sub_diff[63:0];
               if (cnt_ff == 5'd15) begin
                  // rotate the next component into place
                  v_mag_in[0] = v_mag_ff[1];
                  v_mag_in[1] = v_mag_ff[2];
                  v_mag_in[2] = v_mag_ff[0];
                  v_neg_in    = {v_neg_ff[0], v_neg_ff[2:1]};
                  n_in[0]     = n_ff[1];
                  n_in[1]     = n_ff[2];
                  n_in[2]     = n_new;
                  cnt_in      = '0;
                  comp_in     = comp_ff + 1'b1;
                  if (comp_ff == 2'd2) state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            cnt_in  = '0;
            comp_in = '0;
            if (mode_read_ff) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_a_ff;
               rsp_n_in     = n_ff;
               rsp_zero_in  = 1'b0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            sum_raddr = acc_idx;
            sum_waddr = acc_idx;
            sum_wdata = {sat_add(sum_rd_ff[3*SUM_W-1:2*SUM_W], n_ff[0]),
                         sat_add(sum_rd_ff[2*SUM_W-1:SUM_W], n_ff[1]),
                         sat_add(sum_rd_ff[SUM_W-1:0], n_ff[2])};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != 5'd0) begin
               sum_we  = 1'b1;
               cnt_in  = '0;
               comp_in = comp_ff + 1'b1;
               if (comp_ff == 2'd2) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_read_ff <= mode_read_in;
      idx_a_ff     <= idx_a_in;
      idx_b_ff     <= idx_b_in;
      idx_c_ff     <= idx_c_in;
      pa_ff        <= pa_in;
      e_mag_ff     <= e_mag_in;
      e_neg_ff     <= e_neg_in;
      mult_ff      <= mult_in;
      mneg_ff      <= mneg_in;
      acc_ff       <= acc_in;
      v_mag_ff     <= v_mag_in;
      v_neg_ff     <= v_neg_in;
      s_ff         <= s_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      q_ff         <= q_in;
      n_ff         <= n_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_n_ff     <= rsp_n_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_idx_ff;
   assign rsp_normal_x     = rsp_n_ff[0];
   assign rsp_normal_y     = rsp_n_ff[1];
   assign rsp_normal_z     = rsp_n_ff[2];
   assign rsp_zero_normal  = rsp_zero_ff;

endmodule

`default_nettype wire

[rtl/vnavg_checker.sv]
// ----------------------------------------------------------------------------
// vnavg_checker
// Port-level checks of the vertex normal averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vnavg_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic [vnavg_pkg::FUNC_W-1:0]      req_func,
   input wire logic                              rsp_valid,
   input wire logic signed [vnavg_pkg::NRM_W-1:0] rsp_normal_x,
   input wire logic signed [vnavg_pkg::NRM_W-1:0] rsp_normal_y,
   input wire logic signed [vnavg_pkg::NRM_W-1:0] rsp_normal_z,
   input wire logic                              rsp_zero_normal
);

   localparam logic signed [vnavg_pkg::NRM_W-1:0] ONE =
      vnavg_pkg::NRM_W'(vnavg_pkg::NRM_ONE);

   // the clearing pass holds the block busy right after reset
   a_clear_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == vnavg_pkg::FUNC_LOAD) |=> (!busy && !rsp_valid))
      else $error("load did not finish in one cycle");

   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_normal) |->
         (rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0))
      else $error("zero normal flagged with nonzero components");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= ONE && rsp_normal_x >= -ONE &&
                     rsp_normal_y <= ONE && rsp_normal_y >= -ONE &&
                     rsp_normal_z <= ONE && rsp_normal_z >= -ONE))
      else $error("normal component out of unit range");

endmodule

bind vertex_normal_averager_top vnavg_checker u_vnavg_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_normal_x    (rsp_normal_x),
   .rsp_normal_y    (rsp_normal_y),
   .rsp_normal_z    (rsp_normal_z),
   .rsp_zero_normal (rsp_zero_normal)
);

`default_nettype wire

[test/vertex_normal_averager_top_test.sv]
// ----------------------------------------------------------------------------
// vertex_normal_averager_top_test
// Self-checking bench for the vertex normal averager: a shadow copy of the
// position and normal-sum stores predicts each read beat, which is compared
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module vertex_normal_averager_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FUNC_W       = vnavg_pkg::FUNC_W;
   localparam int VTX_W        = vnavg_pkg::VTX_W;
   localparam int POS_W        = vnavg_pkg::POS_W;
   localparam int NRM_W        = vnavg_pkg::NRM_W;
   localparam int SUM_W        = vnavg_pkg::SUM_W;
   localparam int MAX_VERTICES = vnavg_pkg::MAX_VERTICES;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -(longint'(1) <<< (SUM_W - 1));

   typedef struct {
      logic [VTX_W-1:0]        vertex;
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic                    zero;
   } normal_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_W-1:0] req_func = FUNC_UNUSED;
   logic [VTX_W-1:0] req_index_a = '0, req_index_b = '0, req_index_c = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid;
   logic [VTX_W-1:0] rsp_vertex_index;
   logic signed [NRM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_zero_normal;

   normal_beat_type normals_due[$];
   int pos_x_mem[MAX_VERTICES], pos_y_mem[MAX_VERTICES], pos_z_mem[MAX_VERTICES];
   longint sum_x_mem[MAX_VERTICES], sum_y_mem[MAX_VERTICES], sum_z_mem[MAX_VERTICES];
   int errors = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;

   vertex_normal_averager_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_index_a(req_index_a), .req_index_b(req_index_b),
      .req_index_c(req_index_c), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .rsp_valid(rsp_valid),
      .rsp_vertex_index(rsp_vertex_index), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_zero_normal(rsp_zero_normal)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned rem, res, bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic int top_set(longint unsigned v);
      int p;
      p = -1;
      while (v != 0) begin
         v >>= 1;
         p++;
      end
      return p;
   endfunction

   // scale to unit length in Q2.14; returns 1 for a zero vector
   function automatic bit unit_vector(input longint vec[3], output int nrm[3]);
      longint unsigned mag[3], all, sq, r;
      int p;
      all = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = vec[i] < 0 ? -vec[i] : vec[i];
         all |= mag[i];
      end
      nrm = '{0, 0, 0};
      if (all == 0) return 1'b1;
      p = top_set(all);
      for (int i = 0; i < 3; i++) begin
         mag[i] = p > 29 ? mag[i] >> (p - 29) : mag[i] << (29 - p);
         sq += mag[i] * mag[i];
      end
      r = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
         nrm[i] = int'((mag[i] * 16384 + (r >> 1)) / r);
         if (vec[i] < 0) nrm[i] = -nrm[i];
      end
      return 1'b0;
   endfunction

   function automatic longint clamp_sum(longint s);
      return s > SUM_MAX ? SUM_MAX : (s < SUM_MIN ? SUM_MIN : s);
   endfunction

   task automatic accumulate_face(int a, int b, int c);
      longint e[6], cr[3];
      longint unsigned all, m;
      int nrm[3], p, vtx[3];
      e[0] = longint'(pos_x_mem[b]) - pos_x_mem[a];
      e[1] = longint'(pos_y_mem[b]) - pos_y_mem[a];
      e[2] = longint'(pos_z_mem[b]) - pos_z_mem[a];
      e[3] = longint'(pos_x_mem[c]) - pos_x_mem[a];
      e[4] = longint'(pos_y_mem[c]) - pos_y_mem[a];
      e[5] = longint'(pos_z_mem[c]) - pos_z_mem[a];
      all = 0;
      for (int i = 0; i < 6; i++) all |= (e[i] < 0 ? -e[i] : e[i]);
      p = top_set(all);
      // prescale edges so the cross product stays exact
      if (p >= 30) begin
         for (int i = 0; i < 6; i++) begin
            m = (e[i] < 0 ? -e[i] : e[i]) >> (p - 29);
            e[i] = e[i] < 0 ? -longint'(m) : longint'(m);
         end
      end
      cr[0] = e[1] * e[5] - e[2] * e[4];
      cr[1] = e[2] * e[3] - e[0] * e[5];
      cr[2] = e[0] * e[4] - e[1] * e[3];
      if (unit_vector(cr, nrm)) return;
      vtx = '{a, b, c};
      foreach (vtx[i]) begin
         sum_x_mem[vtx[i]] = clamp_sum(sum_x_mem[vtx[i]] + nrm[0]);
         sum_y_mem[vtx[i]] = clamp_sum(sum_y_mem[vtx[i]] + nrm[1]);
         sum_z_mem[vtx[i]] = clamp_sum(sum_z_mem[vtx[i]] + nrm[2]);
      end
   endtask

   task automatic predict_beat(logic [FUNC_W-1:0] f, int a, int b, int c,
                               int x, int y, int z);
      normal_beat_type beat;
      longint v[3];
      int nrm[3];
      case (f)
         vnavg_pkg::FUNC_LOAD: begin
            pos_x_mem[a] = x;
            pos_y_mem[a] = y;
            pos_z_mem[a] = z;
            sum_x_mem[a] = 0;
            sum_y_mem[a] = 0;
            sum_z_mem[a] = 0;
         end
         vnavg_pkg::FUNC_TRIANGLE: accumulate_face(a, b, c);
         vnavg_pkg::FUNC_READ: begin
            v = '{sum_x_mem[a], sum_y_mem[a], sum_z_mem[a]};
            beat.zero = unit_vector(v, nrm);
            beat.vertex = VTX_W'(a);
            beat.nx = NRM_W'(nrm[0]);
            beat.ny = NRM_W'(nrm[1]);
            beat.nz = NRM_W'(nrm[2]);
            normals_due = {normals_due, beat};
         end
         default: ;
      endcase
   endtask

   task automatic send_item(logic [FUNC_W-1:0] f, logic [VTX_W-1:0] a, b, c,
                            logic [POS_W-1:0] x, y, z);
      @(negedge clock);
      // idle the request side at random before presenting the beat
      while (gaps_on && $urandom_range(99) < 37) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_index_a <= a;
      req_index_b <= b;
      req_index_c <= c;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (busy);
      predict_beat(f, int'(a), int'(b), int'(c), x, y, z);
   endtask

   task automatic load_vertex(int v, logic [POS_W-1:0] x, y, z);
      send_item(vnavg_pkg::FUNC_LOAD, VTX_W'(v), VTX_W'($urandom), VTX_W'($urandom),
                x, y, z);
   endtask

   task automatic add_face(int a, int b, int c);
      send_item(vnavg_pkg::FUNC_TRIANGLE, VTX_W'(a), VTX_W'(b), VTX_W'(c),
                $urandom, $urandom, $urandom);
   endtask

   task automatic read_normal(int v);
      send_item(vnavg_pkg::FUNC_READ, VTX_W'(v), VTX_W'($urandom), VTX_W'($urandom),
                $urandom, $urandom, $urandom);
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] random_pos();
      if ($urandom_range(1)) return $urandom;
      return $urandom_range(0, 1 << 22) - (1 << 21);
   endfunction

   task automatic test_directed;
      load_vertex(0, 0, 0, 0);
      load_vertex(1, 32'h0001_0000, 0, 0);
      load_vertex(2, 0, 32'h0001_0000, 0);
      add_face(0, 1, 2);
      read_normal(0);
      read_normal(1);
      add_face(0, 2, 1);  // opposite face cancels the sum
      read_normal(2);
      load_vertex(1023, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      load_vertex(3, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      load_vertex(4, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      add_face(1023, 3, 4);  // huge edges force prescale
      read_normal(1023);
      read_normal(3);
      load_vertex(5, 32'h1234_5678, 32'hffff_0000, 32'h0000_ffff);
      add_face(5, 5, 5);  // degenerate face
      add_face(0, 1, 1);
      read_normal(5);
      read_normal(512);  // never touched
      send_item(FUNC_UNUSED, 10'h3ff, 10'h3ff, 10'h3ff, '1, '1, '1);
      load_vertex(0, 32'hffff_ffff, 1, 32'h8000_0001);
      read_normal(0);
      drain();
   endtask

   // one long back-to-back run: the face normal points along (-1, 1, 0), so
   // x runs into the lower saturation limit and y into the upper one
   task automatic test_saturation;
      gaps_on = 1'b0;
      load_vertex(10, 0, 0, 0);
      load_vertex(11, 0, 0, 32'h0002_0000);
      load_vertex(12, 32'h0002_0000, 32'h0002_0000, 0);
      repeat (740) add_face(10, 11, 12);
      read_normal(10);
      read_normal(11);
      read_normal(12);
      drain();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_mesh;
      int pool[6];
      int sent;
      sent = 0;
      while (sent < 40) begin
         foreach (pool[i]) begin
            pool[i] = $urandom_range(0, MAX_VERTICES - 1);
            load_vertex(pool[i], random_pos(), random_pos(), random_pos());
            sent++;
         end
         repeat ($urandom_range(8, 24)) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4:
                  add_face(pool[$urandom_range(5)], pool[$urandom_range(5)],
                           pool[$urandom_range(5)]);
               5, 6: read_normal(pool[$urandom_range(5)]);
               7: read_normal($urandom_range(0, MAX_VERTICES - 1));
               8: send_item(FUNC_UNUSED, VTX_W'($urandom), VTX_W'($urandom),
                            VTX_W'($urandom), $urandom, $urandom, $urandom);
               default: load_vertex(pool[$urandom_range(5)], random_pos(),
                                    random_pos(), random_pos());
            endcase
            sent++;
         end
      end
      drain();
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      normal_beat_type want;
      if (!reset && rsp_valid) begin
         if (normals_due.size() == 0) begin
            report_mismatch("unexpected beat, vertex", rsp_vertex_index, -1);
         end else begin
            want = normals_due.pop_front();
            if (rsp_vertex_index !== want.vertex)
               report_mismatch("vertex_index", rsp_vertex_index, want.vertex);
            if (rsp_normal_x !== want.nx) report_mismatch("normal_x", rsp_normal_x, want.nx);
            if (rsp_normal_y !== want.ny) report_mismatch("normal_y", rsp_normal_y, want.ny);
            if (rsp_normal_z !== want.nz) report_mismatch("normal_z", rsp_normal_z, want.nz);
            if (rsp_zero_normal !== want.zero)
               report_mismatch("zero_normal", rsp_zero_normal, want.zero);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[vertex_normal_averager_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_saturation();
      test_random_mesh();
      if (errors == 0 && normals_due.size() == 0) begin
         $display("[vertex_normal_averager_top] OK");
      end else begin
         $display("[vertex_normal_averager_top] ERROR");
      end
      $finish;
   end

endmodule
